// ===== rtl/bdpt_pkg.sv =====
// ----------------------------------------------------------------------------
// bdpt_pkg
// shared types and constants of the button debounce and press timer
// ----------------------------------------------------------------------------
package bdpt_pkg;

  localparam int NUM_BUTTONS_DEFAULT = 2;
  localparam int LEVEL_W             = 2;
  localparam int TIME_W              = 32;
  localparam int DUR_W               = 16;

  localparam logic [DUR_W-1:0] DEBOUNCE_RESET = 16'd50;

  localparam logic CMD_POLL = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic LEVEL_RELEASED = 1'b1;
  localparam logic LEVEL_PRESSED  = 1'b0;

  // input beat: levels, now, index, padded to 40 bits
  localparam int IN_TDATA_W  = 40;
  // output beat: pending flag, press time, last activity, padded to 56 bits
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_USED_W  = 1 + DUR_W + TIME_W;

  typedef struct packed {
    logic              accept;
    logic              poll;
    logic              read;
    logic              first_poll;
    logic [TIME_W-1:0] now_ms;
    logic [DUR_W-1:0]  debounce_ms;
  } lane_ctrl_t;

endpackage

// ===== rtl/bdpt_lane.sv =====
// ----------------------------------------------------------------------------
// bdpt_lane
// debounce and press duration state of one button
// ----------------------------------------------------------------------------
module bdpt_lane (
  input  logic                       clk,
  input  logic                       rst,
  input  bdpt_pkg::lane_ctrl_t       ctrl,
  input  logic                       level,
  input  logic                       sel,
  output logic [bdpt_pkg::DUR_W-1:0]  held,
  output logic [bdpt_pkg::TIME_W-1:0] last_edge,
  output logic [bdpt_pkg::DUR_W-1:0]  got
);

  logic                        prev_level;
  logic [bdpt_pkg::TIME_W-1:0] gap;
  logic                        take;

  assign gap  = ctrl.now_ms - last_edge;
  assign take = ctrl.poll && (level != prev_level) &&
                (ctrl.first_poll ||
                 (gap > {{(bdpt_pkg::TIME_W-bdpt_pkg::DUR_W){1'b0}}, ctrl.debounce_ms}));

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_level <= bdpt_pkg::LEVEL_RELEASED;
      last_edge  <= '0;
      held       <= '0;
    end else if (ctrl.accept) begin
      if (take) begin
        prev_level <= level;
        last_edge  <= ctrl.now_ms;
        if (level == bdpt_pkg::LEVEL_PRESSED) begin
          held <= '0;
        end else begin
          held <= gap[bdpt_pkg::DUR_W-1:0];
        end
      end else if (ctrl.read && sel) begin
        held <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      got <= (ctrl.read && sel) ? held : '0;
    end
  end

endmodule

// ===== rtl/bdpt_merge.sv =====
// ----------------------------------------------------------------------------
// bdpt_merge
// combines the lanes: pending flag, read value and latest edge time
// ----------------------------------------------------------------------------
module bdpt_merge #(
  parameter int NUM_BUTTONS = bdpt_pkg::NUM_BUTTONS_DEFAULT
) (
  input  logic [NUM_BUTTONS-1:0][bdpt_pkg::DUR_W-1:0]  held,
  input  logic [NUM_BUTTONS-1:0][bdpt_pkg::TIME_W-1:0] last_edge,
  input  logic [NUM_BUTTONS-1:0][bdpt_pkg::DUR_W-1:0]  got,
  output logic                                        any_pending,
  output logic [bdpt_pkg::DUR_W-1:0]                   press_ms,
  output logic [bdpt_pkg::TIME_W-1:0]                  latest_ms
);

  localparam int LEAVES = 1 << $clog2(NUM_BUTTONS);

  logic [2*LEAVES-1:0][bdpt_pkg::TIME_W-1:0] node;

  // balanced max tree, leaf LEAVES+i holds lane i
  always_comb begin
    node = '0;
    for (int i = 0; i < LEAVES; i++) begin
      if (i < NUM_BUTTONS) begin
        node[LEAVES+i] = last_edge[i];
      end
    end
    for (int k = LEAVES - 1; k >= 1; k--) begin
      node[k] = (node[2*k] > node[2*k+1]) ? node[2*k] : node[2*k+1];
    end
  end

  assign latest_ms = node[1];

  always_comb begin
    any_pending = 1'b0;
    press_ms    = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      any_pending = any_pending | (|held[i]);
      press_ms    = press_ms | got[i];
    end
  end

endmodule

// ===== rtl/button_debounce_press_timer_core.sv =====
// ----------------------------------------------------------------------------
// button_debounce_press_timer_core
// debounces active-low buttons and times how long each one was held
// ----------------------------------------------------------------------------
// One beat in gives one beat out. A poll beat carries all button levels and a
// millisecond timestamp; a read beat returns one button's held time and clears
// it. The block takes one beat per cycle: every button has its own lane that
// updates its state in the cycle of acceptance, and a merge stage combines the
// updated lane state into the result that the result register captures
// when it has room. The result register and the merge stage hold one beat
// each; input stalls only while both are full and the output waits.
// debounce_ms may be written at any time the block is idle; cfg_ready is
// always high.
module button_debounce_press_timer_core #(
  parameter int NUM_BUTTONS = bdpt_pkg::NUM_BUTTONS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // button_levels[1:0], now_ms[33:2], button_index[34], zero padding
  input  logic [bdpt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // command[0]
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // any_release_pending[0], press_ms[16:1], last_activity_ms[48:17], padding
  output logic [bdpt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bdpt_pkg::DUR_W-1:0]          cfg_data
);

  logic [bdpt_pkg::LEVEL_W-1:0] in_levels;
  logic [bdpt_pkg::TIME_W-1:0]  in_now;
  logic                         in_index;
  logic                         in_accept;

  logic [bdpt_pkg::DUR_W-1:0]   debounce_ms;
  logic                         first_poll;
  logic                         s1_valid;
  logic                         out_valid;
  logic                         s1_advance;

  bdpt_pkg::lane_ctrl_t         ctrl;

  logic [NUM_BUTTONS-1:0]                       lane_level;
  logic [NUM_BUTTONS-1:0]                       lane_sel;
  logic [NUM_BUTTONS-1:0][bdpt_pkg::DUR_W-1:0]  lane_held;
  logic [NUM_BUTTONS-1:0][bdpt_pkg::TIME_W-1:0] lane_edge;
  logic [NUM_BUTTONS-1:0][bdpt_pkg::DUR_W-1:0]  lane_got;

  logic                         mrg_any;
  logic [bdpt_pkg::DUR_W-1:0]   mrg_press;
  logic [bdpt_pkg::TIME_W-1:0]  mrg_latest;

  logic                         out_any;
  logic [bdpt_pkg::DUR_W-1:0]   out_press;
  logic [bdpt_pkg::TIME_W-1:0]  out_latest;

  assign in_levels = s_axis_tdata[bdpt_pkg::LEVEL_W-1:0];
  assign in_now    = s_axis_tdata[bdpt_pkg::LEVEL_W +: bdpt_pkg::TIME_W];
  assign in_index  = s_axis_tdata[bdpt_pkg::LEVEL_W + bdpt_pkg::TIME_W];

  assign s1_advance    = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || !out_valid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= bdpt_pkg::DEBOUNCE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      debounce_ms <= cfg_data;
    end
  end

  always_comb begin
    ctrl.accept      = in_accept;
    ctrl.poll        = (s_axis_tuser == bdpt_pkg::CMD_POLL);
    ctrl.read        = (s_axis_tuser == bdpt_pkg::CMD_READ);
    ctrl.first_poll  = first_poll;
    ctrl.now_ms      = in_now;
    ctrl.debounce_ms = debounce_ms;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_poll <= 1'b1;
    end else if (in_accept && ctrl.poll) begin
      first_poll <= 1'b0;
    end
  end

  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
    if (i < bdpt_pkg::LEVEL_W) begin : g_wired
      assign lane_level[i] = in_levels[i];
      assign lane_sel[i]   = (in_index == 1'(i));
    end else begin : g_unwired
      assign lane_level[i] = bdpt_pkg::LEVEL_PRESSED;
      assign lane_sel[i]   = 1'b0;
    end

    bdpt_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .level     (lane_level[i]),
      .sel       (lane_sel[i]),
      .held      (lane_held[i]),
      .last_edge (lane_edge[i]),
      .got       (lane_got[i])
    );
  end

  bdpt_merge #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_merge (
    .held        (lane_held),
    .last_edge   (lane_edge),
    .got         (lane_got),
    .any_pending (mrg_any),
    .press_ms    (mrg_press),
    .latest_ms   (mrg_latest)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
      if (s1_advance) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_any    <= mrg_any;
      out_press  <= mrg_press;
      out_latest <= mrg_latest;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(bdpt_pkg::OUT_TDATA_W-bdpt_pkg::OUT_USED_W){1'b0}},
                          out_latest, out_press, out_any};

endmodule

// ===== rtl/bdpt_checker.sv =====
// ----------------------------------------------------------------------------
// bdpt_port_checks
// port-level checks of the button debounce and press timer
// ----------------------------------------------------------------------------
module bdpt_port_checks (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [bdpt_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  // no result beat right after reset
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result beat shown after reset");

  // input only stalls behind a waiting result
  assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output backpressure");

  // a stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result beat changed");

  // padding bits stay zero
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      (m_axis_tdata[bdpt_pkg::OUT_TDATA_W-1:bdpt_pkg::OUT_USED_W] == '0))
    else $error("result padding not zero");

endmodule

bind button_debounce_press_timer_core bdpt_port_checks u_bdpt_port_checks (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== bench/bdpt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdpt_checker
// watches the button timer streams, predicts every result beat and compares
// ----------------------------------------------------------------------------
module bdpt_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  input  logic [bdpt_pkg::IN_TDATA_W-1:0]   s_tdata,
  input  logic                              s_tuser,
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic [bdpt_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [bdpt_pkg::DUR_W-1:0]        cfg_data,
  output int                                mismatches,
  output int                                reports_due
);

  localparam int BUTTONS = bdpt_pkg::NUM_BUTTONS_DEFAULT;

  typedef struct packed {
    logic [bdpt_pkg::TIME_W-1:0] latest;
    logic [bdpt_pkg::DUR_W-1:0]  press;
    logic                        pending;
  } report_t;

  logic [bdpt_pkg::DUR_W-1:0]  debounce;
  logic                        btn_level [BUTTONS];
  logic [bdpt_pkg::TIME_W-1:0] edge_at   [BUTTONS];
  logic [bdpt_pkg::DUR_W-1:0]  held      [BUTTONS];
  logic                        awaiting_first;
  report_t                     timer_reports [$];
  int                          fail_cnt = 0;
  int                          due_cnt  = 0;

  assign mismatches  = fail_cnt;
  assign reports_due = due_cnt;

  function automatic report_t next_report(input logic cmd,
                                          input logic [bdpt_pkg::LEVEL_W-1:0] levels,
                                          input logic [bdpt_pkg::TIME_W-1:0] now,
                                          input logic idx);
    report_t                     r;
    logic [bdpt_pkg::TIME_W-1:0] gap;
    logic                        lvl;
    r = '0;
    if (cmd == bdpt_pkg::CMD_POLL) begin
      for (int i = 0; i < BUTTONS; i++) begin
        lvl = (i < bdpt_pkg::LEVEL_W) ? levels[i] : bdpt_pkg::LEVEL_PRESSED;
        if (lvl != btn_level[i]) begin
          gap = now - edge_at[i];
          if (awaiting_first || gap > debounce) begin
            held[i]      = (lvl == bdpt_pkg::LEVEL_PRESSED) ? '0 : gap[bdpt_pkg::DUR_W-1:0];
            btn_level[i] = lvl;
            edge_at[i]   = now;
          end
        end
      end
      awaiting_first = 1'b0;
    end else if (idx < BUTTONS) begin
      r.press   = held[idx];
      held[idx] = '0;
    end
    for (int i = 0; i < BUTTONS; i++) begin
      if (held[i] != '0) r.pending = 1'b1;
      if (edge_at[i] > r.latest) r.latest = edge_at[i];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    report_t got;
    report_t want;
    if (rst) begin
      debounce = bdpt_pkg::DEBOUNCE_RESET;
      for (int i = 0; i < BUTTONS; i++) begin
        btn_level[i] = bdpt_pkg::LEVEL_RELEASED;
        edge_at[i]   = '0;
        held[i]      = '0;
      end
      awaiting_first = 1'b1;
      timer_reports.delete();
      due_cnt <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        timer_reports.push_back(next_report(s_tuser, s_tdata[bdpt_pkg::LEVEL_W-1:0],
                                            s_tdata[bdpt_pkg::LEVEL_W +: bdpt_pkg::TIME_W],
                                            s_tdata[bdpt_pkg::LEVEL_W+bdpt_pkg::TIME_W]));
      end
      // a debounce write counts from the next beat on
      if (cfg_valid && cfg_ready) debounce = cfg_data;
      if (m_tvalid && m_tready) begin
        got = report_t'(m_tdata[bdpt_pkg::OUT_USED_W-1:0]);
        if (timer_reports.size() == 0) begin
          $error("result beat with nothing outstanding");
          fail_cnt++;
        end else begin
          want = timer_reports.pop_front();
          if (got.pending !== want.pending) begin
            $error("any_release_pending: expected %0d, got %0d", want.pending, got.pending);
            fail_cnt++;
          end
          if (got.press !== want.press) begin
            $error("press_ms: expected %0d, got %0d", want.press, got.press);
            fail_cnt++;
          end
          if (got.latest !== want.latest) begin
            $error("last_activity_ms: expected %0d, got %0d", want.latest, got.latest);
            fail_cnt++;
          end
        end
      end
      due_cnt <= timer_reports.size();
    end
  end

endmodule

// ===== bench/tb_button_debounce_press_timer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_debounce_press_timer_core
// drives poll and read beats into the button timer under bursty input and
// stalling output, steps the debounce time through its extremes between
// phases, and leaves prediction and comparison to bdpt_checker
// ----------------------------------------------------------------------------
module tb_button_debounce_press_timer_core;

  localparam int IDLE_LIMIT  = 2000;
  localparam int PHASE_BEATS = 225;

  logic                              clk            = 1'b0;
  logic                              rst            = 1'b1;
  logic                              s_axis_tvalid  = 1'b0;
  wire                               s_axis_tready;
  logic [bdpt_pkg::IN_TDATA_W-1:0]   s_axis_tdata   = '0;
  logic                              s_axis_tuser   = bdpt_pkg::CMD_POLL;
  wire                               m_axis_tvalid;
  logic                              m_axis_tready  = 1'b0;
  wire  [bdpt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;
  logic                              cfg_valid      = 1'b0;
  wire                               cfg_ready;
  logic [bdpt_pkg::DUR_W-1:0]        cfg_data       = '0;

  int                                mismatches;
  int                                reports_due;
  int                                idle_cycles    = 0;
  int                                burst_left     = 0;
  logic [7:0]                        stall_pat      = 8'hff;
  int                                stall_age      = 0;
  logic [bdpt_pkg::LEVEL_W-1:0]      cur_levels     = '1;
  logic [bdpt_pkg::TIME_W-1:0]       cur_now        = '0;
  logic [bdpt_pkg::DUR_W-1:0]        dbn_now        = bdpt_pkg::DEBOUNCE_RESET;
  logic [bdpt_pkg::DUR_W-1:0]        phase_dbn [6];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  button_debounce_press_timer_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  bdpt_checker press_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_axis_tvalid),
    .s_tready    (s_axis_tready),
    .s_tdata     (s_axis_tdata),
    .s_tuser     (s_axis_tuser),
    .m_tvalid    (m_axis_tvalid),
    .m_tready    (m_axis_tready),
    .m_tdata     (m_axis_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .reports_due (reports_due)
  );

  // output side stalls on a rotating pattern, reshuffled whenever its age counter wraps
  always @(posedge clk) begin
    if (stall_age == 63) begin
      stall_pat <= ($urandom_range(0, 3) == 0) ? 8'hff : (8'($urandom) | 8'h01);
      stall_age <= 0;
    end else begin
      stall_pat <= {stall_pat[6:0], stall_pat[7]};
      stall_age <= stall_age + 1;
    end
    m_axis_tready <= stall_pat[0];
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_button_debounce_press_timer_core: errors");
      $finish;
    end
  end

  task automatic send_beat(input logic cmd, input logic [bdpt_pkg::LEVEL_W-1:0] lv,
                           input logic [bdpt_pkg::TIME_W-1:0] t, input logic idx);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= bdpt_pkg::IN_TDATA_W'({idx, t, lv});
    s_axis_tuser  <= cmd;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic set_debounce(input logic [bdpt_pkg::DUR_W-1:0] v);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (reports_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    dbn_now   = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    burst_left = 0;
  endtask

  task automatic random_beat();
    logic cmd;
    logic idx;
    int   roll;
    int   bit_sel;
    cmd  = ($urandom_range(0, 99) < 20) ? bdpt_pkg::CMD_READ : bdpt_pkg::CMD_POLL;
    roll = $urandom_range(0, 99);
    if (roll < 65) begin
      bit_sel = $urandom_range(0, bdpt_pkg::LEVEL_W - 1);
      cur_levels[bit_sel] = ~cur_levels[bit_sel];
    end else if (roll < 80) begin
      cur_levels = bdpt_pkg::LEVEL_W'($urandom);
    end
    roll = $urandom_range(0, 99);
    if (roll < 88) begin
      cur_now += $urandom_range(0, 2 * int'(dbn_now) + 4);
    end else if (roll < 95) begin
      cur_now += $urandom;
    end else begin
      cur_now = $urandom;
    end
    idx = 1'($urandom_range(0, 1));
    send_beat(cmd, cur_levels, cur_now, idx);
  endtask

  initial begin
    phase_dbn = '{16'd0, 16'hffff, 16'd1, 16'd0, 16'd20, 16'd300};
    phase_dbn[3] = bdpt_pkg::DUR_W'($urandom);
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // read before any poll, then the first poll ignores the debounce window
    send_beat(bdpt_pkg::CMD_READ, 2'b11, 32'd0,          1'b0);
    send_beat(bdpt_pkg::CMD_POLL, 2'b10, 32'd10,         1'b0);
    // too early, exactly on the window, then one past it
    send_beat(bdpt_pkg::CMD_POLL, 2'b11, 32'd40,         1'b0);
    send_beat(bdpt_pkg::CMD_POLL, 2'b11, 32'd60,         1'b0);
    send_beat(bdpt_pkg::CMD_POLL, 2'b11, 32'd61,         1'b0);
    send_beat(bdpt_pkg::CMD_POLL, 2'b00, 32'd200,        1'b1);
    // hold longer than 16 bits of ms
    send_beat(bdpt_pkg::CMD_POLL, 2'b11, 32'd70200,      1'b0);
    send_beat(bdpt_pkg::CMD_READ, 2'b11, 32'd0,          1'b1);
    send_beat(bdpt_pkg::CMD_READ, 2'b11, 32'd0,          1'b1);
    send_beat(bdpt_pkg::CMD_READ, 2'b00, 32'hffff_ffff,  1'b0);
    send_beat(bdpt_pkg::CMD_POLL, 2'b10, 32'hffff_fff0,  1'b0);
    // timestamp wraps
    send_beat(bdpt_pkg::CMD_POLL, 2'b11, 32'h0000_0030,  1'b1);
    send_beat(bdpt_pkg::CMD_POLL, 2'b01, 32'h0000_0031,  1'b0);
    send_beat(bdpt_pkg::CMD_POLL, 2'b00, 32'h0000_0032,  1'b1);
    send_beat(bdpt_pkg::CMD_POLL, 2'b11, 32'hffff_ffff,  1'b0);
    send_beat(bdpt_pkg::CMD_READ, 2'b11, 32'h0000_0000,  1'b1);
    send_beat(bdpt_pkg::CMD_POLL, 2'b11, 32'h0000_0000,  1'b0);
    send_beat(bdpt_pkg::CMD_READ, 2'b00, 32'h5555_aaaa,  1'b0);
    send_beat(bdpt_pkg::CMD_POLL, 2'b00, 32'haaaa_5555,  1'b1);
    cur_levels = 2'b00;
    cur_now    = 32'haaaa_5555;

    for (int p = 0; p < 6; p++) begin
      set_debounce(phase_dbn[p]);
      repeat (PHASE_BEATS) random_beat();
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (reports_due != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_button_debounce_press_timer_core: clean");
    end else begin
      $display("tb_button_debounce_press_timer_core: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bdpt_pkg.sv
rtl/bdpt_lane.sv
rtl/bdpt_merge.sv
rtl/button_debounce_press_timer_core.sv
rtl/bdpt_checker.sv
bench/bdpt_checker.sv
bench/tb_button_debounce_press_timer_core.sv
